### hdl/ptb_pkg.sv
// ptb_pkg: types, constants and codes shared by the periodic timer bank
// used by every module of the block and by its checker
package ptb_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = 4;   // index of one slot
  localparam int COUNT_W   = 5;   // occupied slots, 0 to MAX_SLOTS
  localparam int DATA_W    = 32;  // period and countdown
  localparam int MASK_W    = 16;

  localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(MAX_SLOTS);

  // operation codes of an input item
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] period_ticks;
  } req_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    status_t           add_status;
    logic [SLOT_W-1:0] assigned_slot;
  } rsp_t;

  // slot store access from the sequencer
  typedef struct packed {
    logic              wr_period_en;
    logic              wr_countdown_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_period;
    logic [DATA_W-1:0] wr_countdown;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

endpackage

### hdl/periodic_task_timer_bank.sv
// Periodic timer bank: sixteen countdown slots served by one decrementer.
// Add item or empty tick: the sequencer goes straight to ST_DONE, which loads the result.
// Tick item: each occupied slot is visited in turn through ST_READ and ST_UPDATE
// via the store read port, then ST_DONE loads the result. A new item is taken only
// back in ST_IDLE; a stalled result holds the sequencer until the receiver takes it.
// Reset (rst, synchronous) empties the table and drops any pending result.
module periodic_task_timer_bank (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ptb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ptb_pkg::rsp_t rsp
);
  import ptb_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_period;
  logic [DATA_W-1:0] rd_countdown;

  // sequencer and shared decrementer
  ptb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .mem_req      (mem_req),
    .rd_period    (rd_period),
    .rd_countdown (rd_countdown)
  );

  // slot store
  ptb_slot_mem u_mem (
    .clk          (clk),
    .mem_req      (mem_req),
    .rd_period    (rd_period),
    .rd_countdown (rd_countdown)
  );

endmodule

### hdl/ptb_slot_mem.sv
// ptb_slot_mem: period and countdown store, one write and one read address
// depends on ptb_pkg
module ptb_slot_mem (
  input  logic                      clk,
  input  ptb_pkg::mem_req_t         mem_req,
  output logic [ptb_pkg::DATA_W-1:0] rd_period,
  output logic [ptb_pkg::DATA_W-1:0] rd_countdown
);
  import ptb_pkg::*;

  logic [DATA_W-1:0] period_mem [MAX_SLOTS];
  logic [DATA_W-1:0] countdown_mem [MAX_SLOTS];

  // writes
  always_ff @(posedge clk) begin
    if (mem_req.wr_period_en) begin
      period_mem[mem_req.wr_addr] <= mem_req.wr_period;
    end
    if (mem_req.wr_countdown_en) begin
      countdown_mem[mem_req.wr_addr] <= mem_req.wr_countdown;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_period    <= period_mem[mem_req.rd_addr];
    rd_countdown <= countdown_mem[mem_req.rd_addr];
  end

endmodule

### hdl/ptb_ctrl.sv
// ptb_ctrl: sequencer that walks the occupied slots with one shared decrementer
// depends on ptb_pkg; drives ptb_slot_mem
module ptb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  ptb_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output ptb_pkg::rsp_t              rsp,
  output ptb_pkg::mem_req_t          mem_req,
  input  logic [ptb_pkg::DATA_W-1:0] rd_period,
  input  logic [ptb_pkg::DATA_W-1:0] rd_countdown
);
  import ptb_pkg::*;

  state_t             state, state_next;
  logic [COUNT_W-1:0] slot_count, slot_count_next;
  logic [SLOT_W-1:0]  idx, idx_next;
  logic [MASK_W-1:0]  res_mask, res_mask_next;
  status_t            res_status, res_status_next;
  logic [SLOT_W-1:0]  res_slot, res_slot_next;
  logic               rsp_load;

  // shared decrementer
  logic [DATA_W-1:0]  dec_in;
  logic [DATA_W-1:0]  dec_out;
  logic               cd_zero;

  assign cd_zero = (rd_countdown == '0);
  assign dec_out = dec_in - DATA_W'(1);

  always_comb begin
    state_next      = state;
    slot_count_next = slot_count;
    idx_next        = idx;
    res_mask_next   = res_mask;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    rsp_load        = 1'b0;
    req_ready       = 1'b0;
    dec_in          = rd_countdown;
    mem_req         = '0;
    mem_req.rd_addr = idx;
    mem_req.wr_addr = idx;

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          res_mask_next   = '0;
          res_status_next = STATUS_OK;
          res_slot_next   = '0;
          idx_next        = '0;
          if (req.operation == OP_ADD) begin
            state_next = ST_DONE;
            if (slot_count >= SLOT_LIMIT) begin
              res_status_next = STATUS_FULL;
            end else if (req.period_ticks == '0) begin
              res_status_next = STATUS_ZERO;
            end else begin
              // claim the next free slot
              dec_in                  = req.period_ticks;
              mem_req.wr_period_en    = 1'b1;
              mem_req.wr_countdown_en = 1'b1;
              mem_req.wr_addr         = slot_count[SLOT_W-1:0];
              mem_req.wr_period       = req.period_ticks;
              mem_req.wr_countdown    = dec_out;
              res_slot_next           = slot_count[SLOT_W-1:0];
              slot_count_next         = slot_count + COUNT_W'(1);
            end
          end else if (slot_count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end

      ST_READ: begin
        state_next = ST_UPDATE;
      end

      ST_UPDATE: begin
        // expire and reload, or count down
        dec_in                  = cd_zero ? rd_period : rd_countdown;
        mem_req.wr_countdown_en = 1'b1;
        mem_req.wr_countdown    = dec_out;
        if (cd_zero) begin
          res_mask_next = res_mask | (MASK_W'(1) << idx);
        end
        if (COUNT_W'(idx) == slot_count - COUNT_W'(1)) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + SLOT_W'(1);
          state_next = ST_READ;
        end
      end

      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_count <= '0;
    end else begin
      state      <= state_next;
      slot_count <= slot_count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    res_mask   <= res_mask_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= '{fire_mask: res_mask, add_status: res_status, assigned_slot: res_slot};
    end
  end

endmodule

### hdl/ptb_checker.sv
// ptb_checker: port-level checks on the periodic timer bank over time
// depends on ptb_pkg; bound to periodic_task_timer_bank below
module ptb_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ptb_pkg::rsp_t rsp
);
  import ptb_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // the block is busy in the cycle after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready straight after an accepted item");

  // a rejected add carries neither mask nor slot
  a_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.add_status != STATUS_OK) |->
      (rsp.fire_mask == '0) && (rsp.assigned_slot == '0))
    else $error("rejected add with mask or slot");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind periodic_task_timer_bank ptb_checker u_ptb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
